>>> src/ev_pilot_charge_controller_unit_assert.svh
// Assertion macros used by the checker of this block.
`ifndef EV_PILOT_CHARGE_CONTROLLER_UNIT_ASSERT_SVH
`define EV_PILOT_CHARGE_CONTROLLER_UNIT_ASSERT_SVH

// Property checked at every rising edge, off while reset is held.
`define EVPCC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("evpcc assertion failed");

// Signal stays put in the cycle after cond.
`define EVPCC_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> $stable(sig)) \
    else $error("evpcc hold assertion failed");

`endif

>>> src/evpcc_pkg.sv
package evpcc_pkg;

  parameter int unsigned ADC_BITS   = 9;
  parameter int unsigned CFG_IDX_W  = 3;
  parameter int unsigned CFG_DATA_W = 16;
  parameter int unsigned WATTS_W    = 16;
  parameter int unsigned DUTY_W     = 8;

  // threshold resets are given on a 9-bit scale
  parameter int unsigned THR_SCALE       = 512;
  parameter int unsigned STANDBY_THR_RST = 475;
  parameter int unsigned VEHICLE_THR_RST = 410;
  parameter int unsigned READY_THR_RST   = 350;
  parameter int unsigned VENT_THR_RST    = 310;
  parameter logic [DUTY_W-1:0] DUTY_FLOOR_RST = 8'd25;

  // duty = floor(min(W,6900)*255/13800) = floor(w*17/920)
  //      = (w * 17 * ceil(2^27/920)) >> 27, exact for w <= 6900
  parameter int unsigned CLAMP_W    = 13;
  parameter logic [CLAMP_W-1:0] MAX_WATTS = 13'd6900;
  parameter int unsigned MULT_W     = 22;
  parameter logic [MULT_W-1:0] DUTY_MULT = 22'd2480113;
  parameter int unsigned DUTY_SHIFT = 27;
  parameter int unsigned PROD_W     = CLAMP_W + MULT_W;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_POWER  = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    LVL_STANDBY = 3'd0,
    LVL_VEHICLE = 3'd1,
    LVL_READY   = 3'd2,
    LVL_VENT    = 3'd3,
    LVL_ERROR   = 3'd4
  } level_e;

  typedef enum logic [2:0] {
    CS_NONE    = 3'd0,
    CS_STANDBY = 3'd1,
    CS_VEHICLE = 3'd2,
    CS_READY   = 3'd3,
    CS_VENT    = 3'd4
  } charge_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STANDBY_THR = 3'd0,
    CFG_VEHICLE_THR = 3'd1,
    CFG_READY_THR   = 3'd2,
    CFG_VENT_THR    = 3'd3,
    CFG_DUTY_FLOOR  = 3'd4
  } cfg_idx_e;

endpackage

>>> src/evpcc_if.sv
interface evpcc_req_if #(
  parameter int unsigned ADC_BITS = evpcc_pkg::ADC_BITS
);
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [ADC_BITS-1:0]               adc_sample;
  logic                              last_in_window;
  logic [evpcc_pkg::WATTS_W-1:0]     power_watts;

  modport source (output valid, req_type, adc_sample, last_in_window, power_watts,
                  input ready);
  modport sink (input valid, req_type, adc_sample, last_in_window, power_watts,
                output ready);
endinterface

interface evpcc_rsp_if #(
  parameter int unsigned ADC_BITS = evpcc_pkg::ADC_BITS
);
  logic                           valid;
  logic                           ready;
  logic [evpcc_pkg::DUTY_W-1:0]   pwm_duty;
  logic                           pilot_pwm_enabled;
  logic                           relay_closed;
  logic [2:0]                     charge_state;
  logic [2:0]                     detected_level;
  logic [ADC_BITS-1:0]            window_peak;

  modport source (output valid, pwm_duty, pilot_pwm_enabled, relay_closed, charge_state,
                         detected_level, window_peak,
                  input ready);
  modport sink (input valid, pwm_duty, pilot_pwm_enabled, relay_closed, charge_state,
                      detected_level, window_peak,
                output ready);
endinterface

interface evpcc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [evpcc_pkg::CFG_IDX_W-1:0]  index;
  logic [evpcc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/ev_pilot_charge_controller_unit.sv
// Control pilot controller for an AC charging station.
// Channels (valid/ready, a beat moves when both are high):
//   req_i : sample beats (req_type 0) carry an ADC reading and a last-in-window
//           flag; power beats (req_type 1) carry the requested watts.
//   rsp_o : one beat per request, showing duty, pilot enable, relay, charge
//           state, last window class and last window peak after that request.
//   cfg_i : register writes (thresholds, duty floor), always ready. Write only
//           while no request is in flight.
// Path: a request is accepted into the input register and its response is
// then registered in the state registers (input register, then state).
// Throughput: one request per cycle unless rsp_o stalls; peak, classification,
// duty mapping and the charge-state update settle combinationally between the
// input and state registers, which double as the result register.
// Stall: while rsp_o is held off, the state registers hold the pending
// response; req_i keeps taking one more beat into the input register and then
// drops ready until the response moves.
// Reset: thresholds 475/410/350/310 (9-bit scale), duty floor 25, charge state
// none, relay open, duty 0, pilot PWM disabled, nothing in flight.
module ev_pilot_charge_controller_unit #(
  parameter int unsigned ADC_BITS = evpcc_pkg::ADC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  evpcc_cfg_if.sink   cfg_i,
  evpcc_req_if.sink   req_i,
  evpcc_rsp_if.source rsp_o
);

  localparam logic [ADC_BITS-1:0] StandbyRst =
    ADC_BITS'((evpcc_pkg::STANDBY_THR_RST * (2 ** ADC_BITS)) / evpcc_pkg::THR_SCALE);
  localparam logic [ADC_BITS-1:0] VehicleRst =
    ADC_BITS'((evpcc_pkg::VEHICLE_THR_RST * (2 ** ADC_BITS)) / evpcc_pkg::THR_SCALE);
  localparam logic [ADC_BITS-1:0] ReadyRst =
    ADC_BITS'((evpcc_pkg::READY_THR_RST * (2 ** ADC_BITS)) / evpcc_pkg::THR_SCALE);
  localparam logic [ADC_BITS-1:0] VentRst =
    ADC_BITS'((evpcc_pkg::VENT_THR_RST * (2 ** ADC_BITS)) / evpcc_pkg::THR_SCALE);

  // configuration
  logic [ADC_BITS-1:0]          standby_thr_q, vehicle_thr_q, ready_thr_q, vent_thr_q;
  logic [evpcc_pkg::DUTY_W-1:0] duty_floor_q;

  // input register
  logic                          in_valid_q;
  evpcc_pkg::req_e               req_type_q;
  logic [ADC_BITS-1:0]           adc_q;
  logic                          last_q;
  logic [evpcc_pkg::WATTS_W-1:0] watts_q;

  // state, also the response payload
  logic                          out_valid_q, out_valid_d;
  logic [ADC_BITS-1:0]           running_peak_q, running_peak_d;
  logic [ADC_BITS-1:0]           last_peak_q, last_peak_d;
  evpcc_pkg::level_e             level_q, level_d;
  evpcc_pkg::charge_e            charge_q, charge_d;
  logic                          relay_q, relay_d;
  logic [evpcc_pkg::DUTY_W-1:0]  req_duty_q, req_duty_d;
  logic [evpcc_pkg::DUTY_W-1:0]  pwm_q, pwm_d;
  logic                          paused_q, paused_d;

  logic                          advance, fire;
  logic [ADC_BITS-1:0]           peak;
  evpcc_pkg::level_e             level_new;
  logic [evpcc_pkg::CLAMP_W-1:0] watts_clamped;
  logic [evpcc_pkg::PROD_W-1:0]  duty_prod;
  logic [evpcc_pkg::DUTY_W-1:0]  duty_raw, duty;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      standby_thr_q <= StandbyRst;
      vehicle_thr_q <= VehicleRst;
      ready_thr_q   <= ReadyRst;
      vent_thr_q    <= VentRst;
      duty_floor_q  <= evpcc_pkg::DUTY_FLOOR_RST;
    end else if (cfg_i.valid) begin
      case (evpcc_pkg::cfg_idx_e'(cfg_i.index))
        evpcc_pkg::CFG_STANDBY_THR: standby_thr_q <= cfg_i.data[ADC_BITS-1:0];
        evpcc_pkg::CFG_VEHICLE_THR: vehicle_thr_q <= cfg_i.data[ADC_BITS-1:0];
        evpcc_pkg::CFG_READY_THR:   ready_thr_q   <= cfg_i.data[ADC_BITS-1:0];
        evpcc_pkg::CFG_VENT_THR:    vent_thr_q    <= cfg_i.data[ADC_BITS-1:0];
        evpcc_pkg::CFG_DUTY_FLOOR:  duty_floor_q  <= cfg_i.data[evpcc_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_type_q <= evpcc_pkg::req_e'(req_i.req_type);
      adc_q      <= req_i.adc_sample;
      last_q     <= req_i.last_in_window;
      watts_q    <= req_i.power_watts;
    end
  end

  // peak and window class
  always_comb begin
    peak = (adc_q > running_peak_q) ? adc_q : running_peak_q;
    if (peak > standby_thr_q) begin
      level_new = evpcc_pkg::LVL_STANDBY;
    end else if (peak > vehicle_thr_q) begin
      level_new = evpcc_pkg::LVL_VEHICLE;
    end else if (peak > ready_thr_q) begin
      level_new = evpcc_pkg::LVL_READY;
    end else if (peak > vent_thr_q) begin
      level_new = evpcc_pkg::LVL_VENT;
    end else begin
      level_new = evpcc_pkg::LVL_ERROR;
    end
  end

  // watts to duty
  always_comb begin
    watts_clamped = (watts_q > evpcc_pkg::WATTS_W'(evpcc_pkg::MAX_WATTS)) ?
                    evpcc_pkg::MAX_WATTS : watts_q[evpcc_pkg::CLAMP_W-1:0];
    duty_prod = evpcc_pkg::PROD_W'(watts_clamped) * evpcc_pkg::PROD_W'(evpcc_pkg::DUTY_MULT);
    duty_raw  = duty_prod[evpcc_pkg::DUTY_SHIFT +: evpcc_pkg::DUTY_W];
    duty      = (duty_raw < duty_floor_q) ? '0 : duty_raw;
  end

  always_comb begin
    out_valid_d    = out_valid_q;
    running_peak_d = running_peak_q;
    last_peak_d    = last_peak_q;
    level_d        = level_q;
    charge_d       = charge_q;
    relay_d        = relay_q;
    req_duty_d     = req_duty_q;
    pwm_d          = pwm_q;
    paused_d       = paused_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (fire) begin
      out_valid_d = 1'b1;
      case (req_type_q)
        evpcc_pkg::REQ_SAMPLE: begin
          if (last_q) begin
            last_peak_d    = peak;
            running_peak_d = '0;
            level_d        = level_new;
            case (level_new)
              evpcc_pkg::LVL_STANDBY: begin
                if (charge_q != evpcc_pkg::CS_STANDBY) begin
                  charge_d = evpcc_pkg::CS_STANDBY;
                  relay_d  = 1'b0;
                end
              end
              evpcc_pkg::LVL_VEHICLE: begin
                if (charge_q != evpcc_pkg::CS_VEHICLE) begin
                  charge_d = evpcc_pkg::CS_VEHICLE;
                  relay_d  = 1'b0;
                end
              end
              evpcc_pkg::LVL_READY, evpcc_pkg::LVL_VENT: begin
                // ready and ventilation are one state for the relay
                if (charge_q != evpcc_pkg::CS_READY && charge_q != evpcc_pkg::CS_VENT) begin
                  charge_d = (level_new == evpcc_pkg::LVL_READY) ?
                             evpcc_pkg::CS_READY : evpcc_pkg::CS_VENT;
                  relay_d  = 1'b1;
                end
              end
              default: ; // error: hold state and relay
            endcase
          end else begin
            running_peak_d = peak;
          end
        end
        evpcc_pkg::REQ_POWER: begin
          if (duty != req_duty_q) begin
            req_duty_d = duty;
            if (!paused_q && duty < duty_floor_q) begin
              pwm_d    = duty_floor_q;
              paused_d = 1'b1;
            end else if (paused_q && duty >= duty_floor_q) begin
              pwm_d    = duty;
              paused_d = 1'b0;
            end else begin
              pwm_d    = duty;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      running_peak_q <= '0;
      last_peak_q    <= '0;
      level_q        <= evpcc_pkg::LVL_STANDBY;
      charge_q       <= evpcc_pkg::CS_NONE;
      relay_q        <= 1'b0;
      req_duty_q     <= '0;
      pwm_q          <= '0;
      paused_q       <= 1'b1;
    end else begin
      out_valid_q    <= out_valid_d;
      running_peak_q <= running_peak_d;
      last_peak_q    <= last_peak_d;
      level_q        <= level_d;
      charge_q       <= charge_d;
      relay_q        <= relay_d;
      req_duty_q     <= req_duty_d;
      pwm_q          <= pwm_d;
      paused_q       <= paused_d;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.pwm_duty          = pwm_q;
  assign rsp_o.pilot_pwm_enabled = !paused_q;
  assign rsp_o.relay_closed      = relay_q;
  assign rsp_o.charge_state      = charge_q;
  assign rsp_o.detected_level    = level_q;
  assign rsp_o.window_peak       = last_peak_q;

endmodule

>>> src/evpcc_checker.sv
`include "ev_pilot_charge_controller_unit_assert.svh"

module evpcc_checker #(
  parameter int unsigned ADC_BITS = evpcc_pkg::ADC_BITS
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic [evpcc_pkg::DUTY_W-1:0] pwm_duty_i,
  input logic                         pilot_pwm_enabled_i,
  input logic                         relay_closed_i,
  input logic [2:0]                   charge_state_i,
  input logic [2:0]                   detected_level_i,
  input logic [ADC_BITS-1:0]          window_peak_i
);

  logic                                  stalled;
  logic [evpcc_pkg::DUTY_W+ADC_BITS+7:0] rsp_payload;
  logic                                  relay_shown, relay_state_ok;
  logic                                  none_shown, none_level_ok;

  assign stalled     = rsp_valid_i && !rsp_ready_i;
  assign rsp_payload = {pwm_duty_i, pilot_pwm_enabled_i, relay_closed_i,
                        charge_state_i, detected_level_i, window_peak_i};

  assign relay_shown    = rsp_valid_i && relay_closed_i;
  assign relay_state_ok = (charge_state_i == evpcc_pkg::CS_READY) ||
                          (charge_state_i == evpcc_pkg::CS_VENT);
  assign none_shown     = rsp_valid_i && (charge_state_i == evpcc_pkg::CS_NONE);
  assign none_level_ok  = (detected_level_i == evpcc_pkg::LVL_STANDBY) ||
                          (detected_level_i == evpcc_pkg::LVL_ERROR);

  `EVPCC_ASSERT(a_rsp_valid_holds, clk_i, rst_ni, stalled |=> rsp_valid_i)

  `EVPCC_ASSERT_HOLD(a_rsp_payload_holds, clk_i, rst_ni, stalled, rsp_payload)

  // contactor only closes in the ready or ventilation state
  `EVPCC_ASSERT(a_relay_needs_ready, clk_i, rst_ni, relay_shown |-> relay_state_ok)

  // no charge state yet means no window closed, or only error windows
  `EVPCC_ASSERT(a_none_means_no_class, clk_i, rst_ni, none_shown |-> none_level_ok)

endmodule

bind ev_pilot_charge_controller_unit evpcc_checker #(.ADC_BITS(ADC_BITS)) u_evpcc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .pwm_duty_i          (rsp_o.pwm_duty),
  .pilot_pwm_enabled_i (rsp_o.pilot_pwm_enabled),
  .relay_closed_i      (rsp_o.relay_closed),
  .charge_state_i      (rsp_o.charge_state),
  .detected_level_i    (rsp_o.detected_level),
  .window_peak_i       (rsp_o.window_peak)
);

>>> tb/sv/tb_ev_pilot_charge_controller_unit.sv
module tb_ev_pilot_charge_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import evpcc_pkg::*;

  localparam int unsigned WATTS_CAP = 6900;
  localparam int unsigned DUTY_SPAN = 255;
  localparam int unsigned DUTY_DIV  = 13800;
  localparam int unsigned ADC_TOP   = (1 << ADC_BITS) - 1;

  typedef struct packed {
    req_e                 kind;
    logic [ADC_BITS-1:0]  sample;
    logic                 last;
    logic [WATTS_W-1:0]   watts;
  } pilot_req_t;

  typedef struct packed {
    logic [DUTY_W-1:0]    pwm;
    logic                 pwm_en;
    logic                 relay;
    logic [2:0]           chg;
    logic [2:0]           lvl;
    logic [ADC_BITS-1:0]  peak;
  } pilot_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  evpcc_req_if req_if ();
  evpcc_rsp_if rsp_if ();
  evpcc_cfg_if cfg_if ();

  ev_pilot_charge_controller_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  // predictor state and register copies
  logic [8:0]          thr_standby, thr_vehicle, thr_ready, thr_vent;
  logic [7:0]          floor_duty;
  logic [ADC_BITS-1:0] peak_run, peak_held;
  level_e              win_level;
  charge_e             chg_state;
  logic                contactor_exp;
  logic [7:0]          duty_req, duty_out;
  logic                pilot_held;

  pilot_status_t status_due[$];
  int unsigned   mismatch_cnt = 0;

  bit req_burst = 1'b0;
  bit rsp_calm  = 1'b0;
  bit rsp_hold  = 1'b0;

  function automatic pilot_status_t pilot_next_status(pilot_req_t it);
    pilot_status_t       st;
    logic [ADC_BITS-1:0] peak;
    int unsigned         w, d;
    if (it.kind == REQ_SAMPLE) begin
      peak = (it.sample > peak_run) ? it.sample : peak_run;
      if (it.last) begin
        peak_held = peak;
        peak_run  = '0;
        // first threshold strictly exceeded wins
        if (peak > thr_standby)      win_level = LVL_STANDBY;
        else if (peak > thr_vehicle) win_level = LVL_VEHICLE;
        else if (peak > thr_ready)   win_level = LVL_READY;
        else if (peak > thr_vent)    win_level = LVL_VENT;
        else                         win_level = LVL_ERROR;
        case (win_level)
          LVL_STANDBY: begin
            if (chg_state != CS_STANDBY) begin
              chg_state     = CS_STANDBY;
              contactor_exp = 1'b0;
            end
          end
          LVL_VEHICLE: begin
            if (chg_state != CS_VEHICLE) begin
              chg_state     = CS_VEHICLE;
              contactor_exp = 1'b0;
            end
          end
          LVL_READY, LVL_VENT: begin
            // ready and ventilation are one state
            if (chg_state != CS_READY && chg_state != CS_VENT) begin
              chg_state     = (win_level == LVL_READY) ? CS_READY : CS_VENT;
              contactor_exp = 1'b1;
            end
          end
          default: ;
        endcase
      end else begin
        peak_run = peak;
      end
    end else begin
      w = (it.watts > WATTS_CAP) ? WATTS_CAP : it.watts;
      d = w * DUTY_SPAN / DUTY_DIV;
      if (d < floor_duty) d = 0;
      if (d != duty_req) begin
        if (!pilot_held && d < floor_duty) begin
          duty_req   = 8'(d);
          duty_out   = floor_duty;
          pilot_held = 1'b1;
        end else begin
          if (pilot_held && d >= floor_duty) pilot_held = 1'b0;
          duty_req = 8'(d);
          duty_out = 8'(d);
        end
      end
    end
    st.pwm    = duty_out;
    st.pwm_en = !pilot_held;
    st.relay  = contactor_exp;
    st.chg    = chg_state;
    st.lvl    = win_level;
    st.peak   = peak_held;
    return st;
  endfunction

  // half the values close to a threshold, so every class boundary gets hit
  function automatic logic [ADC_BITS-1:0] pick_sample();
    int t, v;
    case ($urandom_range(0, 3))
      0:       t = thr_standby;
      1:       t = thr_vehicle;
      2:       t = thr_ready;
      default: t = thr_vent;
    endcase
    if ($urandom_range(0, 1)) v = t + int'($urandom_range(0, 4)) - 2;
    else                      v = $urandom_range(0, ADC_TOP);
    if (v < 0) v = 0;
    if (v > ADC_TOP) v = ADC_TOP;
    return ADC_BITS'(v);
  endfunction

  function automatic logic [WATTS_W-1:0] pick_watts();
    int w;
    case ($urandom_range(0, 3))
      0: w = $urandom_range(0, 65535);
      1: w = $urandom_range(0, 7000);
      2: w = (int'(floor_duty) * DUTY_DIV + DUTY_SPAN - 1) / DUTY_SPAN
             + int'($urandom_range(0, 2)) - 1;
      default: begin
        case ($urandom_range(0, 3))
          0:       w = 0;
          1:       w = WATTS_CAP;
          2:       w = WATTS_CAP + 1;
          default: w = 65535;
        endcase
      end
    endcase
    if (w < 0) w = 0;
    if (w > 65535) w = 65535;
    return WATTS_W'(w);
  endfunction

  task automatic send_item(pilot_req_t it);
    int unsigned gap;
    gap = req_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.req_type       <= it.kind;
    req_if.adc_sample     <= it.sample;
    req_if.last_in_window <= it.last;
    req_if.power_watts    <= it.watts;
    do @(posedge clk_i); while (!req_if.ready);
    status_due.push_back(pilot_next_status(it));
  endtask

  // unused fields carry noise, the block must ignore them
  task automatic send_sample(logic [ADC_BITS-1:0] s, logic last);
    pilot_req_t it;
    it.kind   = REQ_SAMPLE;
    it.sample = s;
    it.last   = last;
    it.watts  = WATTS_W'($urandom);
    send_item(it);
  endtask

  task automatic send_power(logic [WATTS_W-1:0] w);
    pilot_req_t it;
    it.kind   = REQ_POWER;
    it.sample = ADC_BITS'($urandom);
    it.last   = 1'($urandom);
    it.watts  = w;
    send_item(it);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_STANDBY_THR: thr_standby = val[8:0];
      CFG_VEHICLE_THR: thr_vehicle = val[8:0];
      CFG_READY_THR:   thr_ready   = val[8:0];
      CFG_VENT_THR:    thr_vent    = val[8:0];
      CFG_DUTY_FLOOR:  floor_duty  = val[7:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [8:0] s, logic [8:0] v, logic [8:0] r,
                                logic [8:0] vt, logic [7:0] f);
    settle();
    write_reg(CFG_STANDBY_THR, {7'($urandom), s});
    write_reg(CFG_VEHICLE_THR, {7'($urandom), v});
    write_reg(CFG_READY_THR,   {7'($urandom), r});
    write_reg(CFG_VENT_THR,    {7'($urandom), vt});
    write_reg(CFG_DUTY_FLOOR,  {8'($urandom), f});
  endtask

  // whole windows with random content, power beats mixed in, some noise
  task automatic send_random_mix(int unsigned n);
    int unsigned sent, len;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 7) == 0) req_burst = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 24) == 0) rsp_calm <= ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            send_power(pick_watts());
            sent++;
          end
          send_sample(pick_sample(), i == len - 1);
          sent++;
        end
      end else if ($urandom_range(0, 1)) begin
        send_power(WATTS_W'($urandom));
        sent++;
      end else begin
        send_sample(ADC_BITS'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_duty_mapping();
    send_power(16'd0);
    send_power(16'd979);    // maps below the floor, stays paused
    send_power(16'd1353);   // exactly the floor, resumes
    send_power(16'd6900);
    send_power(16'd65535);  // clamped, duty unchanged
    send_power(16'd3000);
    send_power(16'd100);    // pauses, pwm shows the floor
    send_power(16'd1352);
    send_power(16'd6899);
  endtask

  task automatic test_window_classes();
    send_sample(9'd100, 1'b0);
    send_sample(9'd480, 1'b0);
    send_sample(9'd0, 1'b1);
    send_sample(9'd475, 1'b1);  // equal to a threshold is not above it
    send_sample(9'd411, 1'b1);
    send_sample(9'd410, 1'b1);
    send_sample(9'd350, 1'b1);  // ventilation after ready changes nothing
    send_sample(9'd311, 1'b1);
    send_sample(9'd310, 1'b1);  // error holds state and relay
    send_sample(9'd0, 1'b1);
    send_sample(9'd511, 1'b1);
    send_sample(9'd351, 1'b1);
    send_sample(9'd511, 1'b0);
    send_sample(9'd0, 1'b1);
  endtask

  task automatic test_backpressure();
    settle();
    req_burst = 1'b1;
    fork
      begin
        rsp_hold <= 1'b1;
        repeat (150) @(posedge clk_i);
        rsp_hold <= 1'b0;
      end
      repeat (40) begin
        if ($urandom_range(0, 4) == 0) send_power(pick_watts());
        else send_sample(pick_sample(), $urandom_range(0, 3) == 0);
      end
    join
    req_burst = 1'b0;
    settle();
  endtask

  task automatic test_config_sweep();
    logic [8:0] s, v, r, vt;
    apply_settings(9'd0, 9'd0, 9'd0, 9'd0, 8'd0);
    send_random_mix(150);
    apply_settings(9'd511, 9'd511, 9'd511, 9'd511, 8'd255);
    send_random_mix(150);
    apply_settings(9'd511, 9'd0, 9'd511, 9'd0, 8'd1);
    // writes to unused indexes must leave everything alone
    for (int i = CFG_DUTY_FLOOR + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    send_random_mix(150);
    repeat (3) begin
      s  = 9'($urandom_range(300, 511));
      v  = 9'($urandom_range(200, s));
      r  = 9'($urandom_range(100, v));
      vt = 9'($urandom_range(0, r));
      apply_settings(s, v, r, vt, 8'($urandom_range(1, 128)));
      send_random_mix(150);
    end
    apply_settings(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom), 8'($urandom));
    send_random_mix(150);
  endtask

  task automatic test_random_traffic();
    apply_settings(9'd475, 9'd410, 9'd350, 9'd310, 8'd25);
    send_random_mix(650);
  endtask

  // receiver: random stall after each beat, plus the long hold-off
  initial begin : rsp_drain
    int unsigned stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) stall_left = rsp_calm ? 0 : $urandom_range(0, 18);
      else if (stall_left > 0) stall_left--;
      rsp_if.ready <= rst_ni && !rsp_hold && stall_left == 0;
    end
  end

  always @(posedge clk_i) begin : status_check
    pilot_status_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got.pwm    = rsp_if.pwm_duty;
      got.pwm_en = rsp_if.pilot_pwm_enabled;
      got.relay  = rsp_if.relay_closed;
      got.chg    = rsp_if.charge_state;
      got.lvl    = rsp_if.detected_level;
      got.peak   = rsp_if.window_peak;
      if (status_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected status beat, pwm=%0d en=%0b relay=%0b cs=%0d lvl=%0d peak=%0d",
                   $time, got.pwm, got.pwm_en, got.relay, got.chg, got.lvl, got.peak);
      end else begin
        want = status_due.pop_front();
        if (got.pwm !== want.pwm || got.pwm_en !== want.pwm_en ||
            got.relay !== want.relay || got.chg !== want.chg ||
            got.lvl !== want.lvl || got.peak !== want.peak) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: status mismatch exp pwm=%0d en=%0b relay=%0b cs=%0d lvl=%0d peak=%0d%s",
                     $time, want.pwm, want.pwm_en, want.relay, want.chg, want.lvl, want.peak,
                     $sformatf(" got pwm=%0d en=%0b relay=%0b cs=%0d lvl=%0d peak=%0d",
                               got.pwm, got.pwm_en, got.relay, got.chg, got.lvl, got.peak));
        end
      end
    end
  end

  initial begin
    thr_standby   = 9'd475;
    thr_vehicle   = 9'd410;
    thr_ready     = 9'd350;
    thr_vent      = 9'd310;
    floor_duty    = 8'd25;
    peak_run      = '0;
    peak_held     = '0;
    win_level     = LVL_STANDBY;
    chg_state     = CS_NONE;
    contactor_exp = 1'b0;
    duty_req      = '0;
    duty_out      = '0;
    pilot_held    = 1'b1;

    req_if.valid          <= 1'b0;
    req_if.req_type       <= REQ_SAMPLE;
    req_if.adc_sample     <= '0;
    req_if.last_in_window <= 1'b0;
    req_if.power_watts    <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= CFG_STANDBY_THR;
    cfg_if.data           <= '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_duty_mapping();
    test_window_classes();
    test_backpressure();
    test_config_sweep();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && status_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
